// ----- rtl/wpq_pkg.sv -----
package wpq_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int ID_BITS_DEF     = 8;
	localparam int NUM_QUEUES      = 3;
	localparam int SLOT_COUNT      = 13;
	localparam int CURSOR_W        = $clog2(SLOT_COUNT);
	localparam int TASK_W          = 8;
	localparam int PRIO_W          = 2;
	localparam int STATUS_W        = 2;

	localparam logic FUNC_PUSH = 1'b0;
	localparam logic FUNC_POP  = 1'b1;

	localparam logic [PRIO_W-1:0] PRIO_HIGH   = 2'd0;
	localparam logic [PRIO_W-1:0] PRIO_NORMAL = 2'd1;
	localparam logic [PRIO_W-1:0] PRIO_LOW    = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic              func;
		logic [PRIO_W-1:0] priority_req;
		logic [TASK_W-1:0] task_id;
	} in_item_t;

	typedef struct packed {
		logic                granted;
		logic [TASK_W-1:0]   granted_task_id;
		logic [PRIO_W-1:0]   granted_priority;
		logic [STATUS_W-1:0] status;
		logic                any_ready;
	} out_item_t;

	// outcome of the schedule scan
	typedef struct packed {
		logic                found;
		logic [PRIO_W-1:0]   queue;
		logic [CURSOR_W-1:0] next_cursor;
	} pick_t;

	// 13-slot schedule: eight high, four normal, one low
	function automatic logic [PRIO_W-1:0] slot_queue(input logic [CURSOR_W-1:0] slot);
		logic [PRIO_W-1:0] q;
		if (slot < CURSOR_W'(8)) begin
			q = PRIO_HIGH;
		end else if (slot < CURSOR_W'(12)) begin
			q = PRIO_NORMAL;
		end else begin
			q = PRIO_LOW;
		end
		return q;
	endfunction

endpackage

// ----- rtl/weighted_priority_ready_queues_core.sv -----
// Channel | Direction | Handshake              | Payload
// in      | input     | in_valid / in_ready    | in_data  (in_item_t: func, priority_req, task_id)
// out     | output    | out_valid / out_ready  | out_data (out_item_t: granted ... any_ready)
//
// A push or an empty pop has its result registered at the accept edge.
// A pop that finds a task waits on the store: the task store is a synchronous RAM, so the
// head entry arrives in the cycle after the read is issued. One transaction is in flight.
// arst_n clears heads, counts, the cursor and the valid flags; the store holds
// no reset and is only read at entries a push has written.
// in_ready drops while a pop read is pending or while an untaken result blocks the output.
module weighted_priority_ready_queues_core
	import wpq_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	parameter int ID_BITS     = ID_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	localparam int HEAD_W  = $clog2(QUEUE_DEPTH);
	localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int RAM_DEPTH = NUM_QUEUES * QUEUE_DEPTH;
	localparam int ADDR_W  = $clog2(RAM_DEPTH);

	// queue pointers and schedule cursor
	logic [HEAD_W-1:0]   heads_q  [NUM_QUEUES];
	logic [COUNT_W-1:0]  counts_q [NUM_QUEUES];
	logic [COUNT_W-1:0]  counts_d [NUM_QUEUES];
	logic [CURSOR_W-1:0] cursor_q;

	// pop in flight while the RAM returns the head entry
	logic              rd_pend_q;
	logic [PRIO_W-1:0] gprio_s1;
	logic              any_s1;

	logic      out_valid_q;
	out_item_t out_data_q;

	logic                  accept;
	logic                  is_push;
	logic                  is_pop;
	logic [PRIO_W-1:0]     qsel;
	logic                  push_ok;
	logic [COUNT_W:0]      tail_sum;
	logic [HEAD_W-1:0]     tail;
	logic [NUM_QUEUES-1:0] nonempty;
	logic                  any_d;
	pick_t                 pick;

	logic                  ram_we;
	logic                  ram_re;
	logic [ADDR_W-1:0]     waddr;
	logic [ADDR_W-1:0]     raddr;
	logic [ID_BITS-1:0]    wr_id;
	logic [ID_BITS-1:0]    rd_id;
	logic [ID_BITS+TASK_W-1:0] wr_ext;
	logic [ID_BITS+TASK_W-1:0] rd_ext;

	assign in_ready = !rd_pend_q && (!out_valid_q || out_ready);
	assign accept   = in_valid && in_ready;
	assign is_push  = accept && (in_data.func == FUNC_PUSH);
	assign is_pop   = accept && (in_data.func == FUNC_POP);

	// priority three folds onto the low queue
	assign qsel    = (in_data.priority_req > PRIO_LOW) ? PRIO_LOW : in_data.priority_req;
	assign push_ok = counts_q[qsel] != COUNT_W'(QUEUE_DEPTH);

	// tail = (head + count) mod depth; the sum stays below twice the depth
	always_comb begin
		tail_sum = (COUNT_W + 1)'(heads_q[qsel]) + (COUNT_W + 1)'(counts_q[qsel]);
		if (tail_sum >= (COUNT_W + 1)'(QUEUE_DEPTH)) begin
			tail_sum = tail_sum - (COUNT_W + 1)'(QUEUE_DEPTH);
		end
		tail = tail_sum[HEAD_W-1:0];
	end

	always_comb begin
		for (int q = 0; q < NUM_QUEUES; q++) begin
			nonempty[q] = counts_q[q] != '0;
		end
	end

	wpq_sched u_sched (
		.cursor   (cursor_q),
		.nonempty (nonempty),
		.pick     (pick)
	);

	// occupancy after this transaction, also the source of any_ready
	always_comb begin
		any_d = 1'b0;
		for (int q = 0; q < NUM_QUEUES; q++) begin
			counts_d[q] = counts_q[q];
			if (is_push && push_ok && qsel == PRIO_W'(q)) begin
				counts_d[q] = counts_q[q] + 1'b1;
			end
			if (is_pop && pick.found && pick.queue == PRIO_W'(q)) begin
				counts_d[q] = counts_q[q] - 1'b1;
			end
			any_d = any_d | (counts_d[q] != '0);
		end
	end

	// store layout: queue q owns entries q*QUEUE_DEPTH .. q*QUEUE_DEPTH+QUEUE_DEPTH-1
	function automatic logic [ADDR_W-1:0] entry_addr(input logic [PRIO_W-1:0] q,
		input logic [HEAD_W-1:0] idx);
		logic [ADDR_W-1:0] base;
		case (q)
			PRIO_HIGH:   base = '0;
			PRIO_NORMAL: base = ADDR_W'(QUEUE_DEPTH);
			default:     base = ADDR_W'(2 * QUEUE_DEPTH);
		endcase
		return base + ADDR_W'(idx);
	endfunction

	assign wr_ext = {{ID_BITS{1'b0}}, in_data.task_id};
	assign wr_id  = wr_ext[ID_BITS-1:0];
	assign ram_we = is_push && push_ok;
	assign waddr  = entry_addr(qsel, tail);
	assign ram_re = is_pop && pick.found;
	assign raddr  = entry_addr(pick.queue, heads_q[pick.queue]);

	wpq_ram #(
		.WIDTH (ID_BITS),
		.DEPTH (RAM_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (waddr),
		.wdata (wr_id),
		.re    (ram_re),
		.raddr (raddr),
		.rdata (rd_id)
	);

	assign rd_ext = {{TASK_W{1'b0}}, rd_id};

	// pointer update: advance the head on pop, commit counts and cursor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int q = 0; q < NUM_QUEUES; q++) begin
				heads_q[q]  <= '0;
				counts_q[q] <= '0;
			end
			cursor_q <= '0;
		end else begin
			for (int q = 0; q < NUM_QUEUES; q++) begin
				counts_q[q] <= counts_d[q];
			end
			if (ram_re) begin
				heads_q[pick.queue] <= (heads_q[pick.queue] == HEAD_W'(QUEUE_DEPTH - 1)) ?
					'0 : heads_q[pick.queue] + 1'b1;
				cursor_q <= pick.next_cursor;
			end
		end
	end

	// control: pending read flag and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_pend_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_pend_q <= ram_re;
			if (rd_pend_q || (accept && !ram_re)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload: hold the pop's side fields until the RAM data lands
	always_ff @(posedge clk) begin
		if (ram_re) begin
			gprio_s1 <= pick.queue;
			any_s1   <= any_d;
		end
		if (rd_pend_q) begin
			out_data_q.granted          <= 1'b1;
			out_data_q.granted_task_id  <= rd_ext[TASK_W-1:0];
			out_data_q.granted_priority <= gprio_s1;
			out_data_q.status           <= ST_OK;
			out_data_q.any_ready        <= any_s1;
		end else if (accept && !ram_re) begin
			out_data_q.granted          <= 1'b0;
			out_data_q.granted_task_id  <= '0;
			out_data_q.granted_priority <= '0;
			out_data_q.status           <= is_push ? (push_ok ? ST_OK : ST_FULL) : ST_EMPTY;
			out_data_q.any_ready        <= any_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

`ifndef ASSERT_OFF
	// a pending read always lands in the output register on the next edge
	assert property (@(posedge clk) disable iff (!arst_n) rd_pend_q |=> out_valid_q)
		else $error("pop result not delivered after store read");

	// no new transaction is taken while a read is in flight
	assert property (@(posedge clk) disable iff (!arst_n) rd_pend_q |-> !in_ready)
		else $error("input accepted during pending store read");

	// the cursor stays inside the schedule
	assert property (@(posedge clk) disable iff (!arst_n)
		cursor_q < CURSOR_W'(SLOT_COUNT))
		else $error("schedule cursor out of range");

	// a queue never holds more than its depth
	assert property (@(posedge clk) disable iff (!arst_n)
		counts_q[0] <= COUNT_W'(QUEUE_DEPTH) && counts_q[1] <= COUNT_W'(QUEUE_DEPTH)
		&& counts_q[2] <= COUNT_W'(QUEUE_DEPTH))
		else $error("queue occupancy exceeds depth");

	// a granted pop from the high queue leaves that queue one entry shorter
	assert property (@(posedge clk) disable iff (!arst_n)
		ram_re && pick.queue == PRIO_HIGH |=> counts_q[0] == $past(counts_q[0]) - 1'b1)
		else $error("high queue count not decremented on pop");
`endif

endmodule

// ----- rtl/wpq_ram.sv -----
module wpq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 48
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/wpq_sched.sv -----
module wpq_sched
	import wpq_pkg::*;
(
	input  logic [CURSOR_W-1:0]   cursor,
	input  logic [NUM_QUEUES-1:0] nonempty,
	output pick_t                 pick
);

	// walk the schedule from the cursor, wrapping, and stop at the first live slot
	always_comb begin
		logic [CURSOR_W-1:0] slot;
		logic [PRIO_W-1:0]   q;
		pick = '0;
		slot = cursor;
		for (int off = 0; off < SLOT_COUNT; off++) begin
			q = slot_queue(slot);
			if (!pick.found && nonempty[q]) begin
				pick.found       = 1'b1;
				pick.queue       = q;
				pick.next_cursor = (slot == CURSOR_W'(SLOT_COUNT - 1)) ? '0 : slot + 1'b1;
			end
			slot = (slot == CURSOR_W'(SLOT_COUNT - 1)) ? '0 : slot + 1'b1;
		end
	end

endmodule
